@@ sv/smm_pkg.sv @@
// Shared constants, types and helper functions for the scratchpad matrix engine.
// Used by the controller, the datapath and the top level.
`default_nettype none

package smm_pkg;

	localparam int DIM        = 16;
	localparam int ELEM_WIDTH = 8;
	localparam int SP_ROWS    = 256;

	localparam int DEPTH  = SP_ROWS * DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int ROW_W  = $clog2(SP_ROWS);
	localparam int CNT_W  = $clog2(DIM);

	typedef logic [ELEM_WIDTH-1:0] elem_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [ROW_W-1:0]      row_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	// request opcodes
	localparam logic [2:0] CMD_WRITE = 3'd0;
	localparam logic [2:0] CMD_READ  = 3'd1;
	localparam logic [2:0] CMD_MUL   = 3'd2;
	localparam logic [2:0] CMD_FLUSH = 3'd3;

	// result status codes
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_RANGE   = 2'd1;
	localparam logic [1:0] STS_ILLEGAL = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic       clr_wr;
		logic       wr_elem;
		logic       rd_elem;
		logic       mul_load;
		logic       zero_wr;
		logic       issue;
		logic       res_wr;
		logic       out_load;
		logic       out_rd;
		logic [1:0] out_status;
	} smm_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic elem_ok;
		logic mul_bad;
		logic mul_empty;
		logic c_last;
		logic k_last;
		logic i_last;
		logic out_busy;
	} smm_sts_t;

	function automatic addr_t addr_of(input row_t row, input cnt_t col);
		return ADDR_W'(row) * ADDR_W'(DIM) + ADDR_W'(col);
	endfunction

	// sign-extend a byte, then cut to element width
	function automatic elem_t from_byte(input logic signed [7:0] v);
		logic signed [31:0] t;
		t = 32'(v);
		return t[ELEM_WIDTH-1:0];
	endfunction

	// sign-extend an element, then cut to a byte
	function automatic logic [7:0] to_byte(input elem_t e);
		logic signed [ELEM_WIDTH-1:0] s;
		logic signed [31:0]           t;
		s = e;
		t = 32'(s);
		return t[7:0];
	endfunction

endpackage

`default_nettype wire

@@ sv/scratchpad_matmul_engine.sv @@
// Top level of the scratchpad matrix engine: joins controller and datapath.
// Depends on smm_pkg, smm_ctrl and smm_dpath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request: cmd plus its
//   operand fields. Output channel (out_valid / out_stall) returns exactly
//   one result per request: read_value and status.
//   Element write, element read, flush, illegal and rejected requests give
//   their result in the cycle after acceptance and may be issued every
//   cycle while the output is not stalled. A multiply of row_count rows
//   holds in_stall high while it runs: it zeroes each destination row, then
//   per column issues DIM reads, drains the multiply pipeline and writes
//   once, set by the single multiply-accumulate unit and the two-read,
//   one-write scratchpad; its result appears right after the last write.
//   Range checks happen at acceptance, so a rejected multiply writes nothing.
//   Reset: after arst_n rises the scratchpad is cleared one element a cycle,
//   all SP_ROWS * DIM elements (4096 here), with in_stall high throughout.
//   A stalled result holds; a new request is taken only in a cycle where the
//   result register is empty or being drained.
`default_nettype none

module scratchpad_matmul_engine import smm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        cmd,
	input  wire logic [9:0]        elem_row,
	input  wire logic [3:0]        elem_col,
	input  wire logic signed [7:0] elem_value,
	input  wire logic [9:0]        src_a_row,
	input  wire logic [9:0]        src_b_row,
	input  wire logic [9:0]        dst_row,
	input  wire logic [9:0]        row_count,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [7:0]      read_value,
	output logic [1:0]             status
);

	// command and status between the two halves
	smm_cmd_t ctl;
	smm_sts_t sts;

	smm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts),
		.ctl      (ctl)
	);

	smm_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.sts        (sts),
		.elem_row   (elem_row),
		.elem_col   (elem_col),
		.elem_value (elem_value),
		.src_a_row  (src_a_row),
		.src_b_row  (src_b_row),
		.dst_row    (dst_row),
		.row_count  (row_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status)
	);

endmodule

`default_nettype wire

@@ sv/smm_ctrl.sv @@
// Controller state machine of the scratchpad matrix engine.
// Depends on smm_pkg; drives the datapath through smm_cmd_t.
`default_nettype none

module smm_ctrl import smm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] cmd,
	input  wire smm_sts_t   sts,
	output smm_cmd_t        ctl
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ZERO,
		S_ISSUE,
		S_DRAIN,
		S_WRITE
	} state_t;

	state_t state_q;
	logic   drain_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE) || sts.out_busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		ctl = '0;
		unique case (state_q)
			S_CLEAR: ctl.clr_wr = 1'b1;
			S_IDLE: begin
				if (accept) begin
					ctl.out_status = STS_OK;
					unique case (cmd)
						CMD_WRITE: begin
							ctl.out_load = 1'b1;
							ctl.wr_elem  = sts.elem_ok;
							if (!sts.elem_ok)
								ctl.out_status = STS_RANGE;
						end
						CMD_READ: begin
							ctl.out_load = 1'b1;
							ctl.rd_elem  = sts.elem_ok;
							ctl.out_rd   = sts.elem_ok;
							if (!sts.elem_ok)
								ctl.out_status = STS_RANGE;
						end
						CMD_MUL: begin
							if (sts.mul_empty) begin
								ctl.out_load = 1'b1;
							end else if (sts.mul_bad) begin
								ctl.out_load   = 1'b1;
								ctl.out_status = STS_RANGE;
							end else begin
								ctl.mul_load = 1'b1;
							end
						end
						CMD_FLUSH: ctl.out_load = 1'b1;
						default: begin
							ctl.out_load   = 1'b1;
							ctl.out_status = STS_ILLEGAL;
						end
					endcase
				end
			end
			S_ZERO:  ctl.zero_wr = 1'b1;
			S_ISSUE: ctl.issue   = 1'b1;
			S_DRAIN: ctl         = '0;
			S_WRITE: begin
				ctl.res_wr = 1'b1;
				if (sts.c_last && sts.i_last) begin
					ctl.out_load   = 1'b1;
					ctl.out_status = STS_OK;
				end
			end
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			drain_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clr_last) state_q <= S_IDLE;
				S_IDLE: begin
					if (ctl.mul_load)
						state_q <= S_ZERO;
				end
				S_ZERO: if (sts.c_last) state_q <= S_ISSUE;
				S_ISSUE: begin
					if (sts.k_last) begin
						state_q <= S_DRAIN;
						drain_q <= 1'b0;
					end
				end
				S_DRAIN: begin
					drain_q <= 1'b1;
					if (drain_q)
						state_q <= S_WRITE;
				end
				S_WRITE: begin
					if (!sts.c_last)
						state_q <= S_ISSUE;
					else if (sts.i_last)
						state_q <= S_IDLE;
					else
						state_q <= S_ZERO;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ sv/smm_dpath.sv @@
// Datapath of the scratchpad matrix engine: scratchpad memory, counters,
// multiply-accumulate pipeline and result register. Depends on smm_pkg.
`default_nettype none

module smm_dpath import smm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire smm_cmd_t          ctl,
	output smm_sts_t               sts,
	input  wire logic [9:0]        elem_row,
	input  wire logic [3:0]        elem_col,
	input  wire logic signed [7:0] elem_value,
	input  wire logic [9:0]        src_a_row,
	input  wire logic [9:0]        src_b_row,
	input  wire logic [9:0]        dst_row,
	input  wire logic [9:0]        row_count,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [7:0]      read_value,
	output logic [1:0]             status
);

	localparam logic [10:0] ROW_LIM = 11'(SP_ROWS);
	localparam logic [10:0] DIM_X   = 11'(DIM);
	localparam logic [4:0]  DIM_C   = 5'(DIM);
	localparam cnt_t        CNT_MAX = CNT_W'(DIM - 1);

	elem_t mem [DEPTH];

	addr_t      clr_addr_q;
	row_t       a_row_q, b_row_q, d_row_q;
	logic [9:0] n_q;
	cnt_t       c_q, k_q;

	elem_t rdata_a_s1, rdata_b_s1, prod_s2, acc_q;
	logic  valid_s1, valid_s2, first_s1, first_s2;

	logic       out_valid_q, out_rd_q;
	logic [1:0] out_status_q;

	addr_t elem_addr, a_addr, b_addr, d_addr, wa, ra;
	row_t  b_row_k;
	elem_t wd;
	logic  we, re_a;

	assign elem_addr = addr_of(elem_row[ROW_W-1:0], elem_col[CNT_W-1:0]);
	assign b_row_k   = b_row_q + ROW_W'(k_q);
	assign a_addr    = addr_of(a_row_q, k_q);
	assign b_addr    = addr_of(b_row_k, c_q);
	assign d_addr    = addr_of(d_row_q, c_q);

	assign sts.clr_last  = (clr_addr_q == ADDR_W'(DEPTH - 1));
	assign sts.elem_ok   = ({1'b0, elem_row} < ROW_LIM) && ({1'b0, elem_col} < DIM_C);
	assign sts.mul_bad   = ({1'b0, dst_row} + {1'b0, row_count} > ROW_LIM)
	                    || ({1'b0, src_a_row} + {1'b0, row_count} > ROW_LIM)
	                    || ({1'b0, src_b_row} + DIM_X > ROW_LIM);
	assign sts.mul_empty = (row_count == 10'd0);
	assign sts.c_last    = (c_q == CNT_MAX);
	assign sts.k_last    = (k_q == CNT_MAX);
	assign sts.i_last    = (n_q == 10'd1);
	assign sts.out_busy  = out_valid_q && out_stall;

	// memory port select; the commands never overlap
	always_comb begin
		we   = ctl.clr_wr || ctl.zero_wr || ctl.res_wr || ctl.wr_elem;
		re_a = ctl.rd_elem || ctl.issue;
		if (ctl.clr_wr)
			wa = clr_addr_q;
		else if (ctl.wr_elem)
			wa = elem_addr;
		else
			wa = d_addr;
		if (ctl.res_wr)
			wd = acc_q;
		else if (ctl.wr_elem)
			wd = from_byte(elem_value);
		else
			wd = '0;
		ra = ctl.rd_elem ? elem_addr : a_addr;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
	end

	always_ff @(posedge clk) begin
		if (re_a)
			rdata_a_s1 <= mem[ra];
		if (ctl.issue)
			rdata_b_s1 <= mem[b_addr];
		first_s1 <= (k_q == '0);
		prod_s2  <= ELEM_WIDTH'(rdata_a_s1 * rdata_b_s1);
		first_s2 <= first_s1;
		if (valid_s2)
			acc_q <= (first_s2 ? '0 : acc_q) + prod_s2;
	end

	// operand rows and loop counters
	always_ff @(posedge clk) begin
		if (ctl.mul_load) begin
			a_row_q <= src_a_row[ROW_W-1:0];
			b_row_q <= src_b_row[ROW_W-1:0];
			d_row_q <= dst_row[ROW_W-1:0];
			n_q     <= row_count;
		end else if (ctl.res_wr && sts.c_last) begin
			a_row_q <= a_row_q + row_t'(1);
			d_row_q <= d_row_q + row_t'(1);
			n_q     <= n_q - 10'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q   <= '0;
			c_q          <= '0;
			k_q          <= '0;
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			out_valid_q  <= 1'b0;
			out_rd_q     <= 1'b0;
			out_status_q <= STS_OK;
		end else begin
			if (ctl.clr_wr)
				clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + addr_t'(1);
			if (ctl.mul_load)
				c_q <= '0;
			else if (ctl.zero_wr || ctl.res_wr)
				c_q <= sts.c_last ? '0 : c_q + cnt_t'(1);
			if (ctl.mul_load)
				k_q <= '0;
			else if (ctl.issue)
				k_q <= sts.k_last ? '0 : k_q + cnt_t'(1);
			valid_s1 <= ctl.issue;
			valid_s2 <= valid_s1;
			if (ctl.out_load) begin
				out_valid_q  <= 1'b1;
				out_rd_q     <= ctl.out_rd;
				out_status_q <= ctl.out_status;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign read_value = out_rd_q ? to_byte(rdata_a_s1) : 8'sd0;

endmodule

`default_nettype wire

@@ sv/smm_checker.sv @@
// Port-level checks for the scratchpad matrix engine, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module smm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [2:0]        cmd,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic signed [7:0] read_value,
	input wire logic [1:0]        status
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_value) && $stable(status))
		else $error("stalled result changed");

	// a failed request never returns data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != 2'd0 |-> read_value == 8'sd0)
		else $error("nonzero read_value on error status");

	// illegal opcodes answer next cycle
	a_illegal: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd[2] |=> out_valid && status == 2'd2)
		else $error("illegal request not flagged");

	// flush answers next cycle with ok
	a_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == 3'd3 |=> out_valid && status == 2'd0
		&& read_value == 8'sd0)
		else $error("flush result wrong");

endmodule

bind scratchpad_matmul_engine smm_checker u_smm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.cmd        (cmd),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.read_value (read_value),
	.status     (status)
);

`default_nettype wire

@@ test/tb_scratchpad_matmul_engine.sv @@
// Self-checking testbench for scratchpad_matmul_engine: element writes and reads, multiplies,
// flush and illegal requests, checked against a shadow scratchpad kept in the bench.
// Depends on smm_pkg and the scratchpad_matmul_engine RTL.
`default_nettype none

module tb_scratchpad_matmul_engine;
	import smm_pkg::*;

	localparam int IDLE_PCT       = 19;        // per-cycle chance that a side idles
	localparam int DRAIN_CYCLES   = 8;         // quiet cycles after the last result
	localparam int HOLDOFF_CYCLES = 300;       // long receiver hold-off
	localparam int RUN_LIMIT      = 20_000_000;

	// lowest illegal opcode; all codes above the flush code are illegal
	localparam logic [2:0] CMD_ILLEGAL_BASE = CMD_FLUSH + 3'd1;

	typedef struct {
		logic [2:0]        cmd;
		logic [9:0]        elem_row;
		logic [3:0]        elem_col;
		logic signed [7:0] elem_value;
		logic [9:0]        src_a_row;
		logic [9:0]        src_b_row;
		logic [9:0]        dst_row;
		logic [9:0]        row_count;
	} smm_req_t;

	typedef struct {
		logic signed [7:0] read_value;
		logic [1:0]        status;
	} smm_rsp_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_stall;
	logic [2:0]        cmd        = '0;
	logic [9:0]        elem_row   = '0;
	logic [3:0]        elem_col   = '0;
	logic signed [7:0] elem_value = '0;
	logic [9:0]        src_a_row  = '0;
	logic [9:0]        src_b_row  = '0;
	logic [9:0]        dst_row    = '0;
	logic [9:0]        row_count  = '0;
	logic              out_valid;
	logic              out_stall  = 1'b0;
	logic signed [7:0] read_value;
	logic [1:0]        status;

	scratchpad_matmul_engine uut (.*);

	// Shadow copy of the scratchpad and the results still owed by the block.
	elem_t    shadow_pad [DEPTH];
	smm_rsp_t owed_results [$];
	int       mismatch_count = 0;

	// calm: both sides stop idling. hold_ask: cycles the receiver should hold off.
	bit calm     = 1'b0;
	int hold_ask = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow scratchpad and return the result it owes.
	// Multiplies follow the exact order of reads and writes, so a destination
	// that overlaps an operand sees its own freshly zeroed or written elements.
	function automatic smm_rsp_t run_request(input smm_req_t r);
		smm_rsp_t                     rsp;
		logic signed [31:0]           wide;
		logic signed [31:0]           acc;
		logic signed [ELEM_WIDTH-1:0] ea;
		logic signed [ELEM_WIDTH-1:0] eb;
		int                           at;
		int                           a0;
		int                           b0;
		int                           d0;
		int                           n;
		rsp.read_value = '0;
		rsp.status     = STS_OK;
		case (r.cmd)
			CMD_WRITE: begin
				if (r.elem_row >= SP_ROWS || r.elem_col >= DIM) begin
					rsp.status = STS_RANGE;
				end else begin
					at   = int'(r.elem_row) * DIM + int'(r.elem_col);
					wide = r.elem_value;
					shadow_pad[at] = wide[ELEM_WIDTH-1:0];
				end
			end
			CMD_READ: begin
				if (r.elem_row >= SP_ROWS || r.elem_col >= DIM) begin
					rsp.status = STS_RANGE;
				end else begin
					at   = int'(r.elem_row) * DIM + int'(r.elem_col);
					ea   = shadow_pad[at];
					wide = ea;
					rsp.read_value = wide[7:0];
				end
			end
			CMD_MUL: begin
				a0 = r.src_a_row;
				b0 = r.src_b_row;
				d0 = r.dst_row;
				n  = r.row_count;
				// an empty multiply is fine whatever its rows; otherwise check all rows first
				if (n != 0) begin
					if (d0 + n > SP_ROWS || a0 + n > SP_ROWS || b0 + DIM > SP_ROWS) begin
						rsp.status = STS_RANGE;
					end else begin
						for (int i = 0; i < n; i++) begin
							for (int c = 0; c < DIM; c++)
								shadow_pad[(d0 + i) * DIM + c] = '0;
							for (int c = 0; c < DIM; c++) begin
								acc = 0;
								for (int k = 0; k < DIM; k++) begin
									ea  = shadow_pad[(a0 + i) * DIM + k];
									eb  = shadow_pad[(b0 + k) * DIM + c];
									acc = acc + ea * eb;
								end
								shadow_pad[(d0 + i) * DIM + c] = acc[ELEM_WIDTH-1:0];
							end
						end
					end
				end
			end
			CMD_FLUSH: ;
			default: rsp.status = STS_ILLEGAL;
		endcase
		return rsp;
	endfunction

	function automatic smm_req_t make_req(input logic [2:0] c, input int row, input int col,
		input int val, input int a, input int b, input int d, input int n);
		smm_req_t r;
		r.cmd        = c;
		r.elem_row   = 10'(row);
		r.elem_col   = 4'(col);
		r.elem_value = 8'(val);
		r.src_a_row  = 10'(a);
		r.src_b_row  = 10'(b);
		r.dst_row    = 10'(d);
		r.row_count  = 10'(n);
		return r;
	endfunction

	// Random request. Most requests target a small group of rows so that
	// writes, reads and multiplies keep touching the same nonzero data;
	// the fields a command ignores stay random.
	function automatic smm_req_t random_request();
		smm_req_t r;
		int       pick;
		int       sub;
		r.cmd        = 3'($urandom);
		r.elem_row   = 10'($urandom);
		r.elem_col   = 4'($urandom);
		r.elem_value = 8'($urandom);
		r.src_a_row  = 10'($urandom);
		r.src_b_row  = 10'($urandom);
		r.dst_row    = 10'($urandom);
		r.row_count  = 10'($urandom);
		pick = $urandom_range(99);
		sub  = $urandom_range(99);
		if (pick < 68) begin
			r.cmd = (pick < 40) ? CMD_WRITE : CMD_READ;
			if (sub < 80)
				r.elem_row = 10'($urandom_range(47));
			else if (sub < 88)
				r.elem_row = 10'($urandom_range(SP_ROWS - 1, SP_ROWS - 8));
			// otherwise keep the full-range row, mostly out of range
		end else if (pick < 84) begin
			r.cmd = CMD_MUL;
			if (sub < 85) begin
				sub = $urandom_range(99);
				if (sub < 10)
					r.row_count = '0;
				else if (sub < 18)
					r.row_count = 10'($urandom_range(16, 4));
				else
					r.row_count = 10'($urandom_range(3, 1));
				r.src_a_row = 10'($urandom_range(40));
				r.src_b_row = 10'($urandom_range(32));
				// sometimes end the destination exactly at the top row
				if (r.row_count != 0 && $urandom_range(9) == 0)
					r.dst_row = 10'(SP_ROWS - int'(r.row_count));
				else
					r.dst_row = 10'($urandom_range(40));
			end
		end else if (pick < 89) begin
			r.cmd = CMD_FLUSH;
		end else if (pick < 94) begin
			r.cmd = CMD_ILLEGAL_BASE | 3'($urandom_range(3));
		end
		// remaining requests are full-range noise
		return r;
	endfunction

	// Offer one request, hold it until accepted, then record the owed result.
	// Valid stays high after acceptance; the next call either replaces the
	// payload or drops valid, so valid gets one assignment per edge.
	task automatic send_request(input smm_req_t r);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= r.cmd;
		elem_row   <= r.elem_row;
		elem_col   <= r.elem_col;
		elem_value <= r.elem_value;
		src_a_row  <= r.src_a_row;
		src_b_row  <= r.src_b_row;
		dst_row    <= r.dst_row;
		row_count  <= r.row_count;
		do @(posedge clk); while (in_stall);
		owed_results.insert(owed_results.size(), run_request(r));
	endtask

	// Corner elements, extreme values, a never-written element, and rows past the end.
	task automatic test_element_extremes();
		send_request(make_req(CMD_WRITE, 0, 0, -128, 0, 0, 0, 0));
		send_request(make_req(CMD_WRITE, SP_ROWS - 1, DIM - 1, 127, 0, 0, 0, 0));
		send_request(make_req(CMD_WRITE, 0, DIM - 1, -1, 0, 0, 0, 0));
		send_request(make_req(CMD_WRITE, SP_ROWS - 1, 0, 1, 0, 0, 0, 0));
		send_request(make_req(CMD_READ, 0, 0, 0, 0, 0, 0, 0));
		send_request(make_req(CMD_READ, SP_ROWS - 1, DIM - 1, 0, 0, 0, 0, 0));
		send_request(make_req(CMD_READ, 0, DIM - 1, 0, 0, 0, 0, 0));
		send_request(make_req(CMD_READ, SP_ROWS - 1, 0, 0, 0, 0, 0, 0));
		send_request(make_req(CMD_READ, 1, 1, 0, 0, 0, 0, 0));
		send_request(make_req(CMD_WRITE, SP_ROWS, 0, 55, 0, 0, 0, 0));
		send_request(make_req(CMD_WRITE, 1023, 15, -1, 0, 0, 0, 0));
		send_request(make_req(CMD_READ, SP_ROWS, 3, 0, 0, 0, 0, 0));
		send_request(make_req(CMD_READ, 1023, 0, 0, 0, 0, 0, 0));
	endtask

	// Flush, then every illegal opcode.
	task automatic test_command_codes();
		send_request(make_req(CMD_FLUSH, 0, 0, 0, 0, 0, 0, 0));
		for (int c = CMD_ILLEGAL_BASE; c < 8; c++)
			send_request(make_req(3'(c), 0, 0, 0, 0, 0, 0, 0));
	endtask

	// Empty multiply, each kind of out-of-range multiply, overlap, and a full-size run.
	task automatic test_multiply_edges();
		send_request(make_req(CMD_MUL, 0, 0, 0, 1023, 1023, 1023, 0));
		send_request(make_req(CMD_MUL, 0, 0, 0, 0, 0, SP_ROWS - 1, 2));
		send_request(make_req(CMD_MUL, 0, 0, 0, SP_ROWS - 1, 0, 0, 2));
		send_request(make_req(CMD_MUL, 0, 0, 0, 0, SP_ROWS - DIM + 1, 0, 1));
		send_request(make_req(CMD_MUL, 0, 0, 0, 1023, 1023, 1023, 1023));
		// right operand ends on the top row
		send_request(make_req(CMD_MUL, 0, 0, 0, 1, SP_ROWS - DIM, SP_ROWS - 1, 1));
		// destination is the first right-operand row
		send_request(make_req(CMD_MUL, 0, 0, 0, SP_ROWS - 1, 0, 0, 1));
		// every row at once, destination on top of both operands
		send_request(make_req(CMD_MUL, 0, 0, 0, 0, 0, 0, SP_ROWS));
		send_request(make_req(CMD_READ, SP_ROWS - 1, DIM - 1, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count) send_request(random_request());
	endtask

	// Back-to-back traffic with neither side idling.
	task automatic test_steady_stream(input int count);
		calm = 1'b1;
		repeat (count) send_request(random_request());
		calm = 1'b0;
	endtask

	// Hold the output off for a long stretch while requests keep coming,
	// so the result register fills and the block stalls its input.
	task automatic test_output_holdoff(input int count);
		calm     = 1'b1;
		hold_ask = HOLDOFF_CYCLES;
		repeat (count) send_request(random_request());
		calm = 1'b0;
	endtask

	// Take each result, compare it with the oldest owed one, then pick the
	// next stall value: hold-off, calm, or random idling.
	initial begin : result_checker
		smm_rsp_t want;
		int       hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (owed_results.size() == 0) begin
					$error("result with nothing owed: read_value %0d status %0d",
						read_value, status);
					mismatch_count++;
				end else begin
					want = owed_results.pop_front();
					if (read_value !== want.read_value) begin
						$error("read_value: expected %0d, got %0d", want.read_value, read_value);
						mismatch_count++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatch_count++;
					end
				end
			end
			if (hold_left == 0 && hold_ask > 0) begin
				hold_left = hold_ask;
				hold_ask  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("scratchpad_matmul_engine verification failed");
		$finish;
	end

	initial begin
		foreach (shadow_pad[i])
			shadow_pad[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// the block clears its scratchpad after reset; the first request waits on in_stall
		test_element_extremes();
		test_command_codes();
		test_multiply_edges();
		test_random_traffic(450);
		test_steady_stream(250);
		test_output_holdoff(40);
		test_random_traffic(400);
		in_valid <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("scratchpad_matmul_engine verification clean");
		else
			$display("scratchpad_matmul_engine verification failed");
		$finish;
	end

endmodule

`default_nettype wire
